// File: sv/ecpb_pkg.sv
// Shared constants and types for the exact-match palette builder.
// No dependencies; every other file of the block imports this package.
package ecpb_pkg;

   // Default palette depth
   localparam int ECPB_PALETTE_SIZE = 256;

   // Pixel and result field widths
   localparam int ECPB_CHAN_W      = 8;
   localparam int ECPB_RGB_W       = 3 * ECPB_CHAN_W;
   localparam int ECPB_INDEX_OUT_W = 8;
   localparam int ECPB_COUNT_OUT_W = 9;

   // Control bits of a probe as it walks down the cell chain
   typedef struct packed {
      logic active;      // a pixel occupies this slot of the chain
      logic last_pixel;  // pixel closes the image
      logic found;       // matched or stored by an earlier cell
      logic fresh;       // stored as a new palette entry
      logic full;        // palette reached its size
   } probe_ctl_type;

endpackage

// File: sv/ecpb_if.sv
// Valid/ready channel interfaces for the pixel and result streams.
// Depends on ecpb_pkg for the field widths.
interface ecpb_req_if;
   import ecpb_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ECPB_CHAN_W-1:0] red;
   logic [ECPB_CHAN_W-1:0] green;
   logic [ECPB_CHAN_W-1:0] blue;
   logic                   last_pixel;

   modport source (output valid, red, green, blue, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface ecpb_rsp_if;
   import ecpb_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [ECPB_INDEX_OUT_W-1:0] color_index;
   logic                        new_color;
   logic                        overflow;
   logic [ECPB_COUNT_OUT_W-1:0] color_count;
   logic                        image_done;

   modport source (output valid, color_index, new_color, overflow, color_count,
                   image_done, input ready);
   modport sink   (input valid, color_index, new_color, overflow, color_count,
                   image_done, output ready);
endinterface

// File: sv/ecpb_cell.sv
// One palette cell: holds one entry and passes a probe to its right neighbor.
// Depends on ecpb_pkg for the probe control struct and widths.
module ecpb_cell #(
   parameter int PALETTE_SIZE = ecpb_pkg::ECPB_PALETTE_SIZE,
   parameter int CELL_INDEX   = 0,
   localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1,
   localparam int CNT_W = $clog2(PALETTE_SIZE + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  ecpb_pkg::probe_ctl_type       ctl_left,
   input  logic [ecpb_pkg::ECPB_RGB_W-1:0] rgb_left,
   input  logic [IDX_W-1:0]              index_left,
   input  logic [CNT_W-1:0]              count_left,
   output ecpb_pkg::probe_ctl_type       ctl_right,
   output logic [ecpb_pkg::ECPB_RGB_W-1:0] rgb_right,
   output logic [IDX_W-1:0]              index_right,
   output logic [CNT_W-1:0]              count_right
);
   import ecpb_pkg::*;

   localparam bit LAST_CELL = (CELL_INDEX == PALETTE_SIZE - 1);

   logic                  valid_ff, valid_in;
   logic [ECPB_RGB_W-1:0] color_ff, color_in;
   probe_ctl_type         ctl_ff, ctl_in;
   logic [ECPB_RGB_W-1:0] rgb_ff;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  seek;
   logic                  take;
   logic                  claim;

   // Compare against the stored entry, or claim this cell as the next free slot
   always_comb begin
      seek  = ctl_left.active && !ctl_left.found;
      take  = seek && valid_ff && (color_ff == rgb_left);
      claim = seek && !valid_ff;

      ctl_in   = ctl_left;
      index_in = index_left;
      count_in = count_left;

      if (take || claim) begin
         ctl_in.found = 1'b1;
         index_in     = IDX_W'(CELL_INDEX);
      end
      if (claim) begin
         ctl_in.fresh = 1'b1;
      end

      // Count every occupied entry the probe passes, its own included
      if (ctl_left.active && (valid_ff || claim)) begin
         count_in = count_left + CNT_W'(1);
      end

      // The final cell decides overflow: full before this pixel, or filled by it
      if (LAST_CELL && ctl_left.active) begin
         if (valid_ff) begin
            ctl_in.full  = 1'b1;
            ctl_in.fresh = 1'b0;
            index_in     = '0;
         end else if (claim) begin
            ctl_in.full = 1'b1;
         end
      end
   end

   // Update the entry: drop it once the closing pixel has passed
   always_comb begin
      valid_in = valid_ff;
      color_in = color_ff;
      if (ctl_left.active && ctl_left.last_pixel) begin
         valid_in = 1'b0;
      end else if (claim) begin
         valid_in = 1'b1;
      end
      if (claim) begin
         color_in = rgb_left;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ctl_ff   <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
         ctl_ff   <= ctl_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         color_ff <= color_in;
         rgb_ff   <= rgb_left;
         index_ff <= index_in;
         count_ff <= count_in;
      end
   end

   assign ctl_right   = ctl_ff;
   assign rgb_right   = rgb_ff;
   assign index_right = index_ff;
   assign count_right = count_ff;

endmodule

// File: sv/exact_color_palette_builder_unit.sv
// Top level of the exact-match palette builder: a chain of palette cells.
// Depends on ecpb_pkg, ecpb_if (channel interfaces) and ecpb_cell.
//
//   channel | dir | transfer when        | payload
//   --------+-----+----------------------+-------------------------------------------
//   req_bus | in  | valid && ready       | red, green, blue, last_pixel
//   rsp_bus | out | valid && ready       | color_index, new_color, overflow,
//           |     |                      | color_count, image_done
//
// A pixel walks one cell per cycle while the chain advances, and its result is offered
// from the last cell's registers once it has passed every cell; a new pixel can be
// taken every cycle unless a waiting result holds the chain.
// The cell chain holds one register per palette entry.
// Reset clears every cell's valid bit at once; req_bus.ready is low during reset.
// While a result waits on rsp_bus, the whole chain holds and req_bus.ready is low.
module exact_color_palette_builder_unit #(
   parameter int PALETTE_SIZE = ecpb_pkg::ECPB_PALETTE_SIZE
) (
   input  logic       clock,
   input  logic       reset,
   ecpb_req_if.sink   req_bus,
   ecpb_rsp_if.source rsp_bus
);
   import ecpb_pkg::*;

   localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
   localparam int CNT_W = $clog2(PALETTE_SIZE + 1);

   probe_ctl_type         ctl_chain   [PALETTE_SIZE+1];
   logic [ECPB_RGB_W-1:0] rgb_chain   [PALETTE_SIZE+1];
   logic [IDX_W-1:0]      index_chain [PALETTE_SIZE+1];
   logic [CNT_W-1:0]      count_chain [PALETTE_SIZE+1];

   logic advance;
   logic [IDX_W+ECPB_INDEX_OUT_W-1:0] index_wide;
   logic [CNT_W+ECPB_COUNT_OUT_W-1:0] count_wide;

   // Hold the chain while the result at its end is not taken
   assign advance       = !ctl_chain[PALETTE_SIZE].active || rsp_bus.ready;
   assign req_bus.ready = advance && !reset;

   // Launch a fresh probe into the head of the chain
   always_comb begin
      ctl_chain[0]            = '0;
      ctl_chain[0].active     = req_bus.valid && advance;
      ctl_chain[0].last_pixel = req_bus.last_pixel;
      rgb_chain[0]            = {req_bus.red, req_bus.green, req_bus.blue};
      index_chain[0]          = '0;
      count_chain[0]          = '0;
   end

   // Palette cells
   for (genvar g = 0; g < PALETTE_SIZE; g++) begin : g_cell
      ecpb_cell #(
         .PALETTE_SIZE (PALETTE_SIZE),
         .CELL_INDEX   (g)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .advance     (advance),
         .ctl_left    (ctl_chain[g]),
         .rgb_left    (rgb_chain[g]),
         .index_left  (index_chain[g]),
         .count_left  (count_chain[g]),
         .ctl_right   (ctl_chain[g+1]),
         .rgb_right   (rgb_chain[g+1]),
         .index_right (index_chain[g+1]),
         .count_right (count_chain[g+1])
      );
   end

   // Fit index and count to the result fields, keeping their low bits
   assign index_wide = {{ECPB_INDEX_OUT_W{1'b0}}, index_chain[PALETTE_SIZE]};
   assign count_wide = {{ECPB_COUNT_OUT_W{1'b0}}, count_chain[PALETTE_SIZE]};

   // The last cell's registers serve as the result register
   assign rsp_bus.valid       = ctl_chain[PALETTE_SIZE].active;
   assign rsp_bus.color_index = index_wide[ECPB_INDEX_OUT_W-1:0];
   assign rsp_bus.new_color   = ctl_chain[PALETTE_SIZE].fresh;
   assign rsp_bus.overflow    = ctl_chain[PALETTE_SIZE].full;
   assign rsp_bus.color_count = count_wide[ECPB_COUNT_OUT_W-1:0];
   assign rsp_bus.image_done  = ctl_chain[PALETTE_SIZE].last_pixel;

endmodule

// File: sv/ecpb_checker.sv
// Port-level checks for the palette builder, bound to its top level.
// Depends on ecpb_pkg and exact_color_palette_builder_unit.
module ecpb_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_ready,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [ecpb_pkg::ECPB_INDEX_OUT_W-1:0] color_index,
   input logic                                  new_color,
   input logic                                  overflow,
   input logic [ecpb_pkg::ECPB_COUNT_OUT_W-1:0] color_count,
   input logic                                  image_done
);
   import ecpb_pkg::*;

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(color_index)
         && $stable(new_color) && $stable(overflow) && $stable(color_count)
         && $stable(image_done))
      else $error("result changed while stalled");

   // With no result pending the chain must take pixels
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with no result pending");

   // A new entry lands at the next free index
   a_new_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && new_color |->
         color_count[ECPB_INDEX_OUT_W-1:0] == color_index + ECPB_INDEX_OUT_W'(1))
      else $error("new color index does not match count");

   // After overflow, a pixel reports index zero
   a_over_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow && !new_color |-> color_index == '0)
      else $error("nonzero index after overflow");

   // A new entry leaves a nonzero count unless the palette overflowed
   a_new_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && new_color |-> color_count != '0 || overflow)
      else $error("new color with empty palette count");

endmodule

bind exact_color_palette_builder_unit ecpb_checker u_ecpb_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .color_index (rsp_bus.color_index),
   .new_color   (rsp_bus.new_color),
   .overflow    (rsp_bus.overflow),
   .color_count (rsp_bus.color_count),
   .image_done  (rsp_bus.image_done)
);

// File: sim/ecpb_palette_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the exact-match palette builder: predicts each pixel's result
// and compares it with what leaves the block. Depends on ecpb_pkg and ecpb_if.
module ecpb_palette_checker #(
   parameter int PALETTE_SIZE = ecpb_pkg::ECPB_PALETTE_SIZE
) (
   input  logic clock,
   input  logic reset,
   ecpb_req_if  req_mon,
   ecpb_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   results_pending
);
   import ecpb_pkg::*;

   typedef struct packed {
      logic [ECPB_INDEX_OUT_W-1:0] color_index;
      logic                        new_color;
      logic                        overflow;
      logic [ECPB_COUNT_OUT_W-1:0] color_count;
      logic                        image_done;
   } pixel_result_type;

   // Shadow copy of the palette for the current image
   logic [ECPB_RGB_W-1:0] shadow_rgb [PALETTE_SIZE];
   bit                    shadow_used [PALETTE_SIZE];
   int                    shadow_count;
   bit                    shadow_overflowed;

   pixel_result_type expected_results [$];
   int               results_seen;

   function automatic void clear_shadow_palette();
      for (int i = 0; i < PALETTE_SIZE; i++) begin
         shadow_used[i] = 1'b0;
         shadow_rgb[i]  = '0;
      end
      shadow_count      = 0;
      shadow_overflowed = 1'b0;
   endfunction

   // Look the pixel up, store it on a miss, and close the image on its last pixel
   function automatic pixel_result_type index_pixel(input logic [ECPB_RGB_W-1:0] rgb,
                                                    input logic last);
      pixel_result_type res;
      int               idx;
      bit               hit;
      bit               fresh;
      idx   = 0;
      hit   = 1'b0;
      fresh = 1'b0;
      if (!shadow_overflowed) begin
         for (int i = 0; i < PALETTE_SIZE; i++) begin
            if (!hit && i < shadow_count && shadow_used[i] && shadow_rgb[i] == rgb) begin
               idx = i;
               hit = 1'b1;
            end
         end
         if (!hit && shadow_count < PALETTE_SIZE) begin
            idx                       = shadow_count;
            shadow_rgb[shadow_count]  = rgb;
            shadow_used[shadow_count] = 1'b1;
            shadow_count++;
            fresh = 1'b1;
         end
         if (shadow_count >= PALETTE_SIZE)
            shadow_overflowed = 1'b1;
      end
      res.color_index = idx[ECPB_INDEX_OUT_W-1:0];
      res.new_color   = fresh;
      res.overflow    = shadow_overflowed;
      res.color_count = shadow_count[ECPB_COUNT_OUT_W-1:0];
      res.image_done  = last;
      if (last)
         clear_shadow_palette();
      return res;
   endfunction

   // Compare outgoing results first, then predict the pixel taken at this edge
   always @(posedge clock) begin
      pixel_result_type got;
      pixel_result_type want;
      if (reset) begin
         clear_shadow_palette();
         expected_results.delete();
         results_pending = 0;
         mismatch_count  = 0;
         results_seen    = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.color_index = rsp_mon.color_index;
            got.new_color   = rsp_mon.new_color;
            got.overflow    = rsp_mon.overflow;
            got.color_count = rsp_mon.color_count;
            got.image_done  = rsp_mon.image_done;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"result %0d: unexpected transfer ",
                            "idx=%0d new=%0b ovf=%0b cnt=%0d done=%0b"},
                           results_seen, got.color_index, got.new_color, got.overflow,
                           got.color_count, got.image_done);
            end else begin
               want = expected_results.pop_front();
               if (got.color_index !== want.color_index || got.new_color !== want.new_color ||
                   got.overflow !== want.overflow || got.color_count !== want.color_count ||
                   got.image_done !== want.image_done) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"result %0d: expected idx=%0d new=%0b ovf=%0b cnt=%0d ",
                               "done=%0b, got idx=%0d new=%0b ovf=%0b cnt=%0d done=%0b"},
                              results_seen, want.color_index, want.new_color,
                              want.overflow, want.color_count, want.image_done,
                              got.color_index, got.new_color, got.overflow,
                              got.color_count, got.image_done);
               end
            end
            results_seen++;
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(index_pixel({req_mon.red, req_mon.green, req_mon.blue},
                                                   req_mon.last_pixel));
         results_pending = expected_results.size();
      end
   end

endmodule

// File: sim/tb_exact_color_palette_builder_unit.sv
`timescale 1ns / 100ps
// Testbench top for the exact-match palette builder: drives images of pixels
// with random gaps and stalls. Depends on ecpb_pkg, ecpb_if and the checker.
module tb_exact_color_palette_builder_unit;
   import ecpb_pkg::*;

   localparam int PALETTE_SIZE = ECPB_PALETTE_SIZE;
   localparam int PIXEL_TARGET = 2000;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLDOFF_AT   = 400;
   localparam int HOLDOFF_LEN  = 800;

   logic clock = 1'b1;
   logic reset = 1'b1;

   int mismatch_count;
   int results_pending;
   int pixels_sent  = 0;
   int cycle_count  = 0;
   bit sender_calm  = 1'b0;
   bit receiver_calm = 1'b0;

   ecpb_req_if req_bus ();
   ecpb_rsp_if rsp_bus ();

   exact_color_palette_builder_unit #(.PALETTE_SIZE(PALETTE_SIZE)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   ecpb_palette_checker #(.PALETTE_SIZE(PALETTE_SIZE)) i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #1 clock = 1'b0;
      #1 clock = 1'b1;
   end

   // Mostly short gaps, a few long ones, none while calm
   function automatic int pick_gap(input bit calm);
      int r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 95)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Offer one pixel and hold it until the transfer
   task automatic send_pixel(input logic [ECPB_RGB_W-1:0] rgb, input logic last);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.red        <= rgb[23:16];
      req_bus.green      <= rgb[15:8];
      req_bus.blue       <= rgb[7:0];
      req_bus.last_pixel <= last;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Let every outstanding result drain before going on
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0)
         @(negedge clock);
   endtask

   // Image drawn mostly from a small set of colors, so hits dominate
   task automatic send_pool_image(input int len, input int pool_len);
      logic [ECPB_RGB_W-1:0] pool [16];
      logic [ECPB_RGB_W-1:0] rgb;
      for (int i = 0; i < pool_len; i++)
         pool[i] = ECPB_RGB_W'($urandom());
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 99) < 85)
            rgb = pool[$urandom_range(0, pool_len - 1)];
         else
            rgb = ECPB_RGB_W'($urandom());
         send_pixel(rgb, i == len - 1);
      end
   endtask

   // Image with a given number of distinct colors, repeats mixed in,
   // then extra pixels; the last pixel closes the image
   task automatic send_fill_image(input int distinct_target, input int extra);
      logic [ECPB_RGB_W-1:0] seed_rgb;
      logic [ECPB_RGB_W-1:0] step;
      logic [ECPB_RGB_W-1:0] rgb;
      int                    stored;
      seed_rgb = ECPB_RGB_W'($urandom());
      step     = ECPB_RGB_W'($urandom() | 1);
      stored   = 0;
      while (stored < distinct_target) begin
         if (stored > 0 && $urandom_range(0, 3) == 0) begin
            send_pixel(ECPB_RGB_W'(seed_rgb + step * $urandom_range(0, stored - 1)), 1'b0);
         end else begin
            send_pixel(ECPB_RGB_W'(seed_rgb + step * stored),
                       extra == 0 && stored == distinct_target - 1);
            stored++;
         end
      end
      for (int e = 0; e < extra; e++) begin
         if ($urandom_range(0, 1) == 0)
            rgb = ECPB_RGB_W'($urandom());
         else
            rgb = ECPB_RGB_W'(seed_rgb + step * $urandom_range(0, distinct_target - 1));
         send_pixel(rgb, e == extra - 1);
      end
   endtask

   // Give up on a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off that fills the chain
   initial begin
      int stall;
      bit held_off;
      stall    = 0;
      held_off = 1'b0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 299) == 0)
            receiver_calm = !receiver_calm;
         if (!held_off && pixels_sent >= HOLDOFF_AT) begin
            held_off = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLDOFF_LEN) @(negedge clock);
         end else if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall = pick_gap(receiver_calm);
         end
      end
   end

   // Reset, stimulus and verdict
   initial begin
      int pick;
      req_bus.valid      = 1'b0;
      req_bus.red        = '0;
      req_bus.green      = '0;
      req_bus.blue       = '0;
      req_bus.last_pixel = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Channel extremes, hits on earlier entries, closing on a hit
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'h000000, 1'b0);
      send_pixel(24'hFFFFFF, 1'b0);
      send_pixel(24'hFF0000, 1'b0);
      send_pixel(24'h00FF00, 1'b0);
      send_pixel(24'h0000FF, 1'b0);
      send_pixel(24'hAAAAAA, 1'b0);
      send_pixel(24'h555555, 1'b0);
      send_pixel(24'h0000FF, 1'b0);
      send_pixel(24'hFFFFFF, 1'b1);
      // One-pixel image, then the same color again in a cleared palette
      send_pixel(24'h123456, 1'b1);
      send_pixel(24'h123456, 1'b0);
      send_pixel(24'h123457, 1'b0);
      send_pixel(24'hFEDCBA, 1'b1);
      send_pixel(24'h000000, 1'b1);

      // Palette one short of full; filled exactly by the last pixel; overflowed
      send_fill_image(PALETTE_SIZE - 1, 3);
      send_fill_image(PALETTE_SIZE, 0);
      drain_results();
      sender_calm = 1'b1;
      send_fill_image(PALETTE_SIZE, 30);
      sender_calm = 1'b0;

      // Random images until enough pixels went in
      while (pixels_sent < PIXEL_TARGET) begin
         sender_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 4)
            send_fill_image($urandom_range(PALETTE_SIZE - 6, PALETTE_SIZE),
                            $urandom_range(0, 20));
         else if (pick < 12)
            send_pool_image(1, 1);
         else
            send_pool_image($urandom_range(2, 40), $urandom_range(1, 16));
         if ($urandom_range(0, 24) == 0)
            drain_results();
      end

      drain_results();
      repeat (PALETTE_SIZE + 20) @(negedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
